// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the tree-walk decoder.
// Needs a clock clk_i and an active-low reset rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/htwd_pkg.sv =====
// Package of the Huffman tree-walk decoder: sizes, codes and shared types.
// Used by the channel interfaces, the node table and the top level.
package htwd_pkg;

  localparam int MAX_NODES  = 512;
  localparam int COUNT_BITS = 40;
  localparam int ADDR_W     = $clog2(MAX_NODES);
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int BYTE_BITS  = 8;
  localparam int BIT_CNT_W  = $clog2(BYTE_BITS);
  localparam int CFG_W      = 40;
  localparam int CFG_IDX_W  = 1;

  localparam logic [IDX_W-1:0]     NO_CHILD = 9'd511;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BYTE_BITS - 1);

  localparam logic [1:0] ACT_NODE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;

  localparam logic [1:0] KIND_SYM   = 2'd0;
  localparam logic [1:0] KIND_ERR   = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    node_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic node_valid(logic [IDX_W-1:0] idx);
    return (idx != NO_CHILD) && (int'(idx) < MAX_NODES);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(logic [IDX_W-1:0] idx);
    return ADDR_W'(idx);
  endfunction

endpackage

// ===== hdl/htwd_stream_if.sv =====
// Valid/ready channel interfaces for the input items and result items.
// Depends on htwd_pkg for the field widths.
interface htwd_in_if;
  import htwd_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [IDX_W-1:0] node_index;
  logic             node_is_leaf;
  logic [SYM_W-1:0] node_symbol;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic [7:0]       data_byte;
  logic             last_byte;

  modport source (output valid, action, node_index, node_is_leaf, node_symbol,
                  left_child, right_child, data_byte, last_byte, input ready);
  modport sink (input valid, action, node_index, node_is_leaf, node_symbol,
                left_child, right_child, data_byte, last_byte, output ready);
endinterface

interface htwd_out_if;
  import htwd_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic [1:0]       kind;
  logic             count_reached;
  logic             last;

  modport source (output valid, symbol, kind, count_reached, last, input ready);
  modport sink (input valid, symbol, kind, count_reached, last, output ready);
endinterface

// ===== hdl/htwd_node_ram.sv =====
// Node table of the decoder: one write port and one registered read port.
// Depends on htwd_pkg for the entry type and the request struct.
module htwd_node_ram (
  input  logic               clk_i,
  input  htwd_pkg::ram_req_t req_i,
  output htwd_pkg::node_t    rdata_o
);
  import htwd_pkg::*;

  node_t mem [MAX_NODES];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/huffman_tree_walk_decoder.sv =====
// Huffman decoder that walks a loaded node table one compressed bit at a time.
// A node write or a start is taken in the idle state. A data byte that walks
// the tree goes through a start step and a root read, then for every bit a
// bit step that picks the child and reads it from the node table and a child
// step that looks at the child entry that comes back. When the root is a leaf
// its symbol is given once per bit while the count is still owed. Results
// pass through a one-entry holding stage and an output register, so a stalled
// sink stalls the decoder. Results of one item carry last on the final one.
// Depends on htwd_pkg, htwd_stream_if, htwd_node_ram and assert_macros.svh.
module huffman_tree_walk_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  htwd_in_if.sink                         in_i,
  htwd_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [htwd_pkg::CFG_W-1:0]      cfg_data_i
);
  import htwd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROOT, S_BIT, S_CHILD, S_REP, S_TAIL, S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      root_q, root_d;
  logic [CFG_W-1:0]      expected_q, expected_d;
  logic [IDX_W-1:0]      walk_q, walk_d;
  logic [COUNT_BITS-1:0] emitted_q, emitted_d;
  logic                  err_q, err_d;
  logic [7:0]            byte_q, byte_d;
  logic                  last_q, last_d;
  logic [BIT_CNT_W-1:0]  bitcnt_q, bitcnt_d;
  logic [SYM_W-1:0]      sym_q, sym_d;
  logic                  pend_v_q, pend_v_d;
  logic [SYM_W-1:0]      pend_sym_q, pend_sym_d;
  logic [1:0]            pend_kind_q, pend_kind_d;
  logic                  pend_reached_q, pend_reached_d;
  logic                  out_v_q, out_v_d;
  logic [SYM_W-1:0]      out_sym_q, out_sym_d;
  logic [1:0]            out_kind_q, out_kind_d;
  logic                  out_reached_q, out_reached_d;
  logic                  out_last_q, out_last_d;

  ram_req_t              ram_req;
  node_t                 rd;

  logic [COUNT_BITS-1:0] target;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  reached_eq;
  logic                  cnt_done;
  logic                  owed;
  logic                  slot_free;
  logic                  can_prod;
  logic                  prod;
  logic [SYM_W-1:0]      prod_sym;
  logic [1:0]            prod_kind;
  logic                  prod_reached;
  logic [IDX_W-1:0]      child;

  htwd_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rd)
  );

  // The one incrementer and the comparators shared by every count decision.
  assign target     = COUNT_BITS'(expected_q);
  assign cnt_inc    = emitted_q + COUNT_BITS'(1);
  assign reached_eq = (cnt_inc == target);
  assign cnt_done   = (cnt_inc >= target);
  assign owed       = (emitted_q < target);

  assign slot_free = !out_v_q || out_o.ready;
  assign can_prod  = !pend_v_q || slot_free;
  assign child     = byte_q[bitcnt_q] ? rd.right : rd.left;

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_v_q;
  assign out_o.symbol        = out_sym_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.count_reached = out_reached_q;
  assign out_o.last          = out_last_q;

  always_comb begin
    state_d        = state_q;
    root_d         = root_q;
    expected_d     = expected_q;
    walk_d         = walk_q;
    emitted_d      = emitted_q;
    err_d          = err_q;
    byte_d         = byte_q;
    last_d         = last_q;
    bitcnt_d       = bitcnt_q;
    sym_d          = sym_q;
    pend_v_d       = pend_v_q;
    pend_sym_d     = pend_sym_q;
    pend_kind_d    = pend_kind_q;
    pend_reached_d = pend_reached_q;
    out_v_d        = out_v_q && !out_o.ready;
    out_sym_d      = out_sym_q;
    out_kind_d     = out_kind_q;
    out_reached_d  = out_reached_q;
    out_last_d     = out_last_q;
    ram_req        = '0;
    prod           = 1'b0;
    prod_sym       = '0;
    prod_kind      = KIND_SYM;
    prod_reached   = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROOT:  root_d = cfg_data_i[IDX_W-1:0];
        REG_COUNT: expected_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (in_i.action)
            ACT_NODE: begin
              if (int'(in_i.node_index) < MAX_NODES) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = to_addr(in_i.node_index);
                ram_req.wdata = '{leaf: in_i.node_is_leaf, symbol: in_i.node_symbol,
                                  left: in_i.left_child, right: in_i.right_child};
              end
            end
            ACT_START: begin
              walk_d    = root_q;
              emitted_d = '0;
              err_d     = 1'b0;
            end
            ACT_DATA: begin
              byte_d  = in_i.data_byte;
              last_d  = in_i.last_byte;
              state_d = S_START;
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        if (err_q) begin
          if (can_prod) begin
            prod      = 1'b1;
            prod_kind = KIND_ERR;
            state_d   = S_DONE;
          end
        end else if (!owed) begin
          state_d = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = to_addr(root_q);
          state_d       = S_ROOT;
        end
      end
      S_ROOT: begin
        bitcnt_d = LAST_BIT;
        if (node_valid(root_q) && rd.leaf) begin
          sym_d   = rd.symbol;
          state_d = S_REP;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = to_addr(walk_q);
          state_d       = S_BIT;
        end
      end
      S_BIT: begin
        if (!node_valid(walk_q) || !node_valid(child)) begin
          if (can_prod) begin
            prod      = 1'b1;
            prod_kind = KIND_ERR;
            err_d     = 1'b1;
            state_d   = S_DONE;
          end
        end else begin
          walk_d        = child;
          ram_req.re    = 1'b1;
          ram_req.raddr = to_addr(child);
          state_d       = S_CHILD;
        end
      end
      S_CHILD: begin
        if (rd.leaf) begin
          if (can_prod) begin
            prod         = 1'b1;
            prod_sym     = rd.symbol;
            prod_reached = reached_eq;
            emitted_d    = cnt_inc;
            walk_d       = root_q;
            if (cnt_done) begin
              state_d = S_DONE;
            end else if (bitcnt_q == '0) begin
              state_d = S_TAIL;
            end else begin
              bitcnt_d      = bitcnt_q - BIT_CNT_W'(1);
              ram_req.re    = 1'b1;
              ram_req.raddr = to_addr(root_q);
              state_d       = S_BIT;
            end
          end
        end else if (bitcnt_q == '0) begin
          state_d = S_TAIL;
        end else begin
          bitcnt_d = bitcnt_q - BIT_CNT_W'(1);
          state_d  = S_BIT;
        end
      end
      S_REP: begin
        if (can_prod) begin
          prod         = 1'b1;
          prod_sym     = sym_q;
          prod_reached = reached_eq;
          emitted_d    = cnt_inc;
          if (cnt_done) begin
            state_d = S_DONE;
          end else if (bitcnt_q == '0) begin
            state_d = S_TAIL;
          end else begin
            bitcnt_d = bitcnt_q - BIT_CNT_W'(1);
          end
        end
      end
      S_TAIL: begin
        if (last_q && owed) begin
          if (can_prod) begin
            prod      = 1'b1;
            prod_kind = KIND_SHORT;
            state_d   = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          out_v_d       = 1'b1;
          out_sym_d     = pend_sym_q;
          out_kind_d    = pend_kind_q;
          out_reached_d = pend_reached_q;
          out_last_d    = 1'b1;
          pend_v_d      = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A new result pushes the held one out; only the final one gets last.
    if (prod) begin
      if (pend_v_q) begin
        out_v_d       = 1'b1;
        out_sym_d     = pend_sym_q;
        out_kind_d    = pend_kind_q;
        out_reached_d = pend_reached_q;
        out_last_d    = 1'b0;
      end
      pend_v_d       = 1'b1;
      pend_sym_d     = prod_sym;
      pend_kind_d    = prod_kind;
      pend_reached_d = prod_reached;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      root_q     <= '0;
      expected_q <= '0;
      walk_q     <= '0;
      emitted_q  <= '0;
      err_q      <= 1'b0;
      bitcnt_q   <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      root_q     <= root_d;
      expected_q <= expected_d;
      walk_q     <= walk_d;
      emitted_q  <= emitted_d;
      err_q      <= err_d;
      bitcnt_q   <= bitcnt_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q         <= byte_d;
    last_q         <= last_d;
    sym_q          <= sym_d;
    pend_sym_q     <= pend_sym_d;
    pend_kind_q    <= pend_kind_d;
    pend_reached_q <= pend_reached_d;
    out_sym_q      <= out_sym_d;
    out_kind_q     <= out_kind_d;
    out_reached_q  <= out_reached_d;
    out_last_q     <= out_last_d;
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_idle_no_pend, state_q == S_IDLE, !pend_v_q, "held result left in idle")
  `ASSERT_IMPL(a_err_is_last, out_v_q && out_kind_q == KIND_ERR, out_last_q,
               "error result is not the last of its item")
  `ASSERT_IMPL(a_reached_last, out_v_q && out_reached_q,
               out_kind_q == KIND_SYM && out_last_q, "count reached on a non-final result")
  `ASSERT_PROP(a_child_after_bit,
               state_q == S_CHILD |-> $past(state_q) == S_BIT || $past(state_q) == S_CHILD,
               "child step without a bit step")

endmodule

// ===== bench/htwd_checker.sv =====
// Scoreboard for the Huffman tree-walk decoder: keeps its own node table and registers,
// predicts the result items of every accepted input item and compares them in order.
// Depends on htwd_pkg and the channel interfaces of htwd_stream_if.
module htwd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  htwd_in_if                             in_i,
  htwd_out_if                            out_i,
  input  logic                           cfg_we_i,
  input  logic [htwd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [htwd_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import htwd_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [1:0]       kind;
    logic             reached;
    logic             last;
  } decoded_t;

  node_t                 tree_mem [MAX_NODES];
  logic [IDX_W-1:0]      root_q;
  logic [IDX_W-1:0]      walk_q;
  logic [COUNT_BITS-1:0] target_q;
  logic [COUNT_BITS-1:0] emitted_q;
  logic                  broken_q;
  decoded_t              decoded_q[$];
  decoded_t              byte_q[$];
  decoded_t              seen;
  int                    fails;
  int                    checked;

  function automatic logic index_present(logic [IDX_W-1:0] idx);
    return idx != NO_CHILD && int'(idx) < MAX_NODES;
  endfunction

  function automatic void add_result(logic [SYM_W-1:0] sym, logic [1:0] kind, logic reached);
    decoded_t r;
    r.symbol  = sym;
    r.kind    = kind;
    r.reached = reached;
    r.last    = 1'b0;
    byte_q.push_back(r);
  endfunction

  function automatic void emit_symbol(logic [SYM_W-1:0] sym);
    emitted_q = emitted_q + 1'b1;
    add_result(sym, KIND_SYM, emitted_q == target_q);
  endfunction

  task automatic decode_byte(input logic [7:0] bits, input logic final_byte);
    node_t            cur;
    logic [IDX_W-1:0] next_idx;
    logic             stop;
    decoded_t         r;
    stop = 1'b0;
    byte_q.delete();
    if (broken_q) begin
      add_result('0, KIND_ERR, 1'b0);
    end else if (emitted_q < target_q) begin
      if (index_present(root_q)) cur = tree_mem[root_q];
      else cur = '0;
      if (index_present(root_q) && cur.leaf) begin
        for (int n = 0; n < 8 && emitted_q < target_q; n++) emit_symbol(cur.symbol);
      end else begin
        for (int b = 7; b >= 0 && !stop; b--) begin
          if (!index_present(walk_q)) begin
            broken_q = 1'b1;
            stop = 1'b1;
          end else begin
            cur = tree_mem[walk_q];
            next_idx = bits[b] ? cur.right : cur.left;
            if (!index_present(next_idx)) begin
              broken_q = 1'b1;
              stop = 1'b1;
            end else begin
              walk_q = next_idx;
              cur = tree_mem[next_idx];
              if (cur.leaf) begin
                emit_symbol(cur.symbol);
                walk_q = root_q;
                stop = emitted_q >= target_q;
              end
            end
          end
        end
        if (broken_q) add_result('0, KIND_ERR, 1'b0);
      end
      if (!broken_q && final_byte && emitted_q < target_q) add_result('0, KIND_SHORT, 1'b0);
    end
    foreach (byte_q[i]) begin
      r = byte_q[i];
      r.last = (i == byte_q.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q = '0;
      walk_q = '0;
      target_q = '0;
      emitted_q = '0;
      broken_q = 1'b0;
      decoded_q.delete();
      fails = 0;
      checked = 0;
      pending_o <= 0;
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        seen.symbol  = out_i.symbol;
        seen.kind    = out_i.kind;
        seen.reached = out_i.count_reached;
        seen.last    = out_i.last;
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("unexpected result: symbol %02h kind %0d reached %0b last %0b",
                     seen.symbol, seen.kind, seen.reached, seen.last);
        end else begin
          if (seen !== decoded_q[0]) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display({"result %0d differs: expected symbol %02h kind %0d reached %0b",
                        " last %0b, got symbol %02h kind %0d reached %0b last %0b"},
                       checked, decoded_q[0].symbol, decoded_q[0].kind,
                       decoded_q[0].reached, decoded_q[0].last,
                       seen.symbol, seen.kind, seen.reached, seen.last);
          end
          void'(decoded_q.pop_front());
          checked++;
        end
      end
      if (in_i.valid && in_i.ready) begin
        case (in_i.action)
          ACT_NODE: begin
            if (int'(in_i.node_index) < MAX_NODES)
              tree_mem[in_i.node_index] = {in_i.node_is_leaf, in_i.node_symbol,
                                           in_i.left_child, in_i.right_child};
          end
          ACT_START: begin
            walk_q = root_q;
            emitted_q = '0;
            broken_q = 1'b0;
          end
          ACT_DATA: decode_byte(in_i.data_byte, in_i.last_byte);
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ROOT:  root_q = cfg_data_i[IDX_W-1:0];
          REG_COUNT: target_q = cfg_data_i[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      pending_o <= decoded_q.size();
      fail_count_o <= fails;
      checked_o <= checked;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the tree-walk decoder bench: clock, reset, stimulus and the verdict.
// Loads Huffman trees, decodes directed and random streams with random idling on
// both channels; htwd_checker does the prediction. Depends on htwd_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import htwd_pkg::*;

  localparam int                    RUN_ITEMS   = 110;
  localparam int                    SETTLE_CYC  = 48;
  localparam int                    CYCLE_LIMIT = 400000;
  localparam logic [1:0]            ACT_NONE    = 2'd3;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   fail_count;
  int                   pending;
  int                   checked;
  int                   cycles = 0;
  int                   sent_items = 0;
  int                   phases = 0;
  int                   rx_wait;
  bit                   tx_calm = 1'b0;
  bit                   rx_calm = 1'b0;
  bit                   node_written [MAX_NODES];
  bit                   slot_taken [MAX_NODES];
  int                   written_idx[$];

  htwd_in_if  in_if();
  htwd_out_if out_if();

  huffman_tree_walk_decoder u_dut (
    .clk_i,
    .rst_ni,
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  htwd_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int draw;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) rx_calm <= !rx_calm;
      if (out_if.valid && out_if.ready) begin
        draw = rx_calm ? 0 : $urandom_range(0, 19);
        rx_wait <= draw;
        out_if.ready <= (draw == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_if.ready <= (rx_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                           input logic leaf, input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc,
                           input logic [7:0] data, input logic lastb);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.node_index   <= idx;
    in_if.node_is_leaf <= leaf;
    in_if.node_symbol  <= sym;
    in_if.left_child   <= lc;
    in_if.right_child  <= rc;
    in_if.data_byte    <= data;
    in_if.last_byte    <= lastb;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (act != ACT_NONE) sent_items++;
  endtask

  // Node children always point at written entries or at no child, so a walk
  // never reads a table entry that was never loaded.
  function automatic logic [IDX_W-1:0] any_child();
    if (written_idx.size() == 0 || $urandom_range(0, 3) == 0) return NO_CHILD;
    return IDX_W'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
  endfunction

  function automatic int fresh_slot();
    int idx;
    idx = $urandom_range(0, MAX_NODES - 2);
    while (slot_taken[idx]) idx = $urandom_range(0, MAX_NODES - 2);
    slot_taken[idx] = 1'b1;
    return idx;
  endfunction

  task automatic send_node(input int idx, input logic leaf, input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc);
    send_item(ACT_NODE, IDX_W'(idx), leaf, sym, lc, rc, 8'($urandom), 1'($urandom));
    if (!node_written[idx]) begin
      node_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
  endtask

  task automatic send_start();
    send_item(ACT_START, IDX_W'($urandom), 1'($urandom), 8'($urandom), IDX_W'($urandom),
              IDX_W'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_data(input logic [7:0] data, input logic lastb);
    send_item(ACT_DATA, IDX_W'($urandom), 1'($urandom), 8'($urandom), IDX_W'($urandom),
              IDX_W'($urandom), data, lastb);
  endtask

  task automatic send_noise();
    send_item(ACT_NONE, IDX_W'($urandom), 1'($urandom), 8'($urandom), IDX_W'($urandom),
              IDX_W'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_decoder_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [IDX_W-1:0] root, input logic [COUNT_BITS-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ROOT;
    cfg_data_i  <= CFG_W'(root);
    @(posedge clk_i);
    cfg_index_i <= REG_COUNT;
    cfg_data_i  <= CFG_W'(count);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Builds a random tree bottom-up: leaves first, then inner nodes joining two
  // subtrees. With miss_pct above zero some inner nodes lose one child.
  task automatic build_tree(input int leaves, input int miss_pct, output int root);
    int               pool[$];
    int               idx;
    int               a;
    int               b;
    int               k;
    logic [IDX_W-1:0] lc;
    logic [IDX_W-1:0] rc;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    for (int n = 0; n < leaves; n++) begin
      idx = fresh_slot();
      send_node(idx, 1'b1, 8'($urandom), any_child(), any_child());
      pool.push_back(idx);
    end
    while (pool.size() > 1) begin
      k = $urandom_range(0, pool.size() - 1);
      a = pool[k];
      pool.delete(k);
      k = $urandom_range(0, pool.size() - 1);
      b = pool[k];
      pool.delete(k);
      lc = IDX_W'(a);
      rc = IDX_W'(b);
      if ($urandom_range(0, 99) < miss_pct) begin
        if ($urandom_range(0, 1) == 0) lc = NO_CHILD;
        else rc = NO_CHILD;
      end
      idx = fresh_slot();
      send_node(idx, 1'b0, 8'($urandom), lc, rc);
      pool.push_back(idx);
    end
    root = pool[0];
  endtask

  initial begin
    int                    root;
    int                    leaves;
    int                    miss;
    int                    nbytes;
    logic [COUNT_BITS-1:0] count;
    rst_ni = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.action       <= ACT_NONE;
    in_if.node_index   <= '0;
    in_if.node_is_leaf <= 1'b0;
    in_if.node_symbol  <= '0;
    in_if.left_child   <= '0;
    in_if.right_child  <= '0;
    in_if.data_byte    <= '0;
    in_if.last_byte    <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= '0;
    cfg_data_i         <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two-leaf tree at the table edges: bit 0 gives 00, bit 1 gives FF.
    send_node(0, 1'b1, 8'h00, NO_CHILD, NO_CHILD);
    send_node(510, 1'b1, 8'hFF, 9'd0, 9'd0);
    send_node(1, 1'b0, 8'h3C, 9'd0, 9'd510);
    wait_decoder_idle();
    set_config(9'd1, COUNT_MAX);
    send_start();
    send_data(8'h00, 1'b0);
    send_data(8'hFF, 1'b1);
    send_noise();
    wait_decoder_idle();
    set_config(9'd1, '0);
    send_start();
    send_data(8'h5A, 1'b1);
    wait_decoder_idle();
    set_config(9'd1, 40'd3);
    send_start();
    send_data(8'h96, 1'b0);
    send_data(8'h0F, 1'b1);
    wait_decoder_idle();
    // Root with no right child: a one bit hits a missing child, which sticks.
    send_node(2, 1'b0, 8'h00, 9'd0, NO_CHILD);
    wait_decoder_idle();
    set_config(9'd2, 40'd5);
    send_start();
    send_data(8'h40, 1'b0);
    send_data(8'hC3, 1'b1);
    send_start();
    send_data(8'h00, 1'b1);
    wait_decoder_idle();
    // The root itself is a leaf, so each byte yields up to eight copies.
    set_config(9'd510, 40'd11);
    send_start();
    send_data(8'h81, 1'b0);
    send_data(8'h7E, 1'b1);
    send_data(8'h18, 1'b0);

    while (sent_items < RUN_ITEMS) begin
      phases++;
      case ($urandom_range(0, 9))
        0: begin
          leaves = 1;
          miss = 0;
        end
        1, 2: begin
          leaves = $urandom_range(2, 6);
          miss = 35;
        end
        default: begin
          leaves = $urandom_range(2, 8);
          miss = 0;
        end
      endcase
      build_tree(leaves, miss, root);
      wait_decoder_idle();
      case ($urandom_range(0, 7))
        0: count = '0;
        1: count = COUNT_MAX;
        2: count = COUNT_BITS'({$urandom(), $urandom()});
        default: count = COUNT_BITS'($urandom_range(1, 24));
      endcase
      set_config(IDX_W'(root), count);
      if ($urandom_range(0, 19) != 0) send_start();
      nbytes = $urandom_range(1, 6);
      for (int n = 0; n < nbytes; n++) begin
        case ($urandom_range(0, 19))
          0: send_noise();
          1: send_node(written_idx[$urandom_range(0, written_idx.size() - 1)],
                       1'($urandom), 8'($urandom), any_child(), any_child());
          2: wait_decoder_idle();
          default: ;
        endcase
        send_data(8'($urandom), n == nbytes - 1);
      end
      if ($urandom_range(0, 3) == 0) send_data(8'($urandom), 1'($urandom));
    end
    wait_decoder_idle();

    $display("Sent %0d items: directed cases plus %0d random tree phases.", sent_items, phases);
    $display("Compared %0d results; %0d were wrong or unexpected.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
